// ----- rtl/core/m4mu_pkg.sv -----
// ----------------------------------------------------------------------------
// m4mu_pkg
// Shared widths and saturation limits for the 4x4 matrix multiply unit.
// ----------------------------------------------------------------------------
package m4mu_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned PROD_W    = 2 * VALUE_W;
  localparam int unsigned OUT_IDX_W = 2;

  localparam logic [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

endpackage

// ----- rtl/core/matrix4_multiply_unit.sv -----
// ----------------------------------------------------------------------------
// matrix4_multiply_unit
// Fixed-point DIM x DIM matrix product on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): one transaction carries one element
// of A and the matching element of B, row-major. in_ready_o is high while the
// block loads; the DIM*DIM-th transaction closes the run.
// Output channel (out_valid_o/out_ready_i): DIM*DIM transactions of A times B
// in row-major order, each with its row and column, the last one flagged.
// Values are signed Q(32-FRAC_BITS).FRAC_BITS; each sum of DIM full 64-bit
// products is shifted right arithmetically by FRAC_BITS and saturated, and
// saturated_o marks clipped elements.
// Timing: one multiply-accumulate is issued per cycle while no output stall
// holds the pipeline, DIM^3 in total. Each sum passes through the operand
// read, product, accumulator and output registers. A run loads DIM*DIM
// pairs and then issues DIM^3 products; no new pair is accepted while the
// run computes. Loading of the next run starts right after the last issue
// and overlaps the drain of the pipeline.
// Stall: while a result waits on out_ready_i, the whole compute pipeline
// holds. Reset clears the load count and empties the pipeline; the operand
// memories are not cleared, since every entry is written before it is read.
// ----------------------------------------------------------------------------
module matrix4_multiply_unit import m4mu_pkg::*; #(
  parameter int unsigned DIM       = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [VALUE_W-1:0] a_value_i,
  input  logic signed [VALUE_W-1:0] b_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [VALUE_W-1:0] product_value_o,
  output logic [OUT_IDX_W-1:0]     row_index_o,
  output logic [OUT_IDX_W-1:0]     column_index_o,
  output logic                     last_of_run_o,
  output logic                     saturated_o
);

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned CNT_W = $clog2(DIM);
  localparam int unsigned IDX_W = $clog2(CELLS);
  localparam int unsigned ACC_W = PROD_W + CNT_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DIM - 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CELLS - 1);

  typedef enum logic {
    ST_LOAD,
    ST_COMPUTE
  } state_e;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } tag_t;

  logic signed [VALUE_W-1:0] a_mem [CELLS];
  logic signed [VALUE_W-1:0] b_mem [CELLS];

  state_e           state_q;
  logic [IDX_W-1:0] load_cnt_q;
  logic [CNT_W-1:0] row_q, col_q, k_q;

  logic                      s1_valid_q, s2_valid_q, acc_done_q, out_valid_q;
  tag_t                      s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [VALUE_W-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;

  logic signed [VALUE_W-1:0] out_value_q;
  logic [OUT_IDX_W-1:0]      out_row_q, out_col_q;
  logic                      out_last_q, out_sat_q;

  logic                      en;
  logic                      in_fire;
  logic                      issue;
  logic                      issue_last;
  logic [IDX_W-1:0]          a_addr, b_addr;
  tag_t                      issue_tag;
  logic signed [PROD_W-1:0]  mult;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-VALUE_W:0]    shifted_hi;
  logic                      sat_pos, sat_neg;

  assign en         = !(out_valid_q && !out_ready_i);
  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_COMPUTE) && en;
  assign issue_last = (row_q == CNT_MAX) && (col_q == CNT_MAX) && (k_q == CNT_MAX);

  assign a_addr = IDX_W'(row_q * DIM + k_q);
  assign b_addr = IDX_W'(k_q * DIM + col_q);

  assign issue_tag.first = (k_q == '0);
  assign issue_tag.last  = (k_q == CNT_MAX);
  assign issue_tag.row   = row_q;
  assign issue_tag.col   = col_q;

  assign mult     = a_rd_q * b_rd_q;
  assign acc_base = s2_tag_q.first ? '0 : acc_q;

  assign shifted    = acc_q >>> FRAC_BITS;
  assign shifted_hi = shifted[ACC_W-1:VALUE_W-1];
  assign sat_pos    = !shifted[ACC_W-1] && (|shifted_hi);
  assign sat_neg    = shifted[ACC_W-1] && !(&shifted_hi);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_mem[load_cnt_q] <= a_value_i;
      b_mem[load_cnt_q] <= b_value_i;
    end
    if (issue) begin
      a_rd_q <= a_mem[a_addr];
      b_rd_q <= b_mem[b_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (load_cnt_q == IDX_MAX) begin
              load_cnt_q <= '0;
              row_q      <= '0;
              col_q      <= '0;
              k_q        <= '0;
              state_q    <= ST_COMPUTE;
            end else begin
              load_cnt_q <= load_cnt_q + 1'b1;
            end
          end
        end
        ST_COMPUTE: begin
          if (issue) begin
            if (issue_last) begin
              state_q <= ST_LOAD;
            end
            if (k_q == CNT_MAX) begin
              k_q <= '0;
              if (col_q == CNT_MAX) begin
                col_q <= '0;
                row_q <= row_q + 1'b1;
              end else begin
                col_q <= col_q + 1'b1;
              end
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
      if (en) begin
        out_valid_q <= acc_done_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      acc_done_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      acc_done_q <= s2_valid_q && s2_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_tag_q <= issue_tag;
      s2_tag_q <= s1_tag_q;
      prod_q   <= mult;
      if (s2_valid_q) begin
        s3_tag_q <= s2_tag_q;
        acc_q    <= acc_base + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end
      if (acc_done_q) begin
        out_row_q   <= OUT_IDX_W'(s3_tag_q.row);
        out_col_q   <= OUT_IDX_W'(s3_tag_q.col);
        out_last_q  <= (s3_tag_q.row == CNT_MAX) && (s3_tag_q.col == CNT_MAX);
        out_sat_q   <= sat_pos || sat_neg;
        out_value_q <= sat_pos ? SAT_MAX :
                       sat_neg ? SAT_MIN : shifted[VALUE_W-1:0];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = out_value_q;
  assign row_index_o     = out_row_q;
  assign column_index_o  = out_col_q;
  assign last_of_run_o   = out_last_q;
  assign saturated_o     = out_sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (load_cnt_q == IDX_MAX) |=> (state_q == ST_COMPUTE))
    else $error("run did not start computing after its last load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && issue_last |=> in_ready_o && (load_cnt_q == '0))
    else $error("load phase did not resume after the last issue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(acc_q) && $stable(prod_q))
    else $error("pipeline moved during an output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (product_value_o == SAT_MAX) || (product_value_o == SAT_MIN))
    else $error("saturated element not at a range limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |->
      (row_index_o == OUT_IDX_W'(DIM - 1)) && (column_index_o == OUT_IDX_W'(DIM - 1)))
    else $error("last flag on an element other than the final one");

endmodule
